// ===== hw/rtl/ppdh_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdh_pkg
// shared constants, types and codes of the pair distance histogram
// ----------------------------------------------------------------------------
package ppdh_pkg;

   localparam int HIST_BINS_DEF   = 64;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int COUNT_WIDTH_DEF = 32;

   // configuration register indexes
   localparam logic [2:0] REG_RANGE_MIN     = 3'd0;
   localparam logic [2:0] REG_RANGE_MAX     = 3'd1;
   localparam logic [2:0] REG_INV_BIN_WIDTH = 3'd2;
   localparam logic [2:0] REG_BINS_IN_USE   = 3'd3;
   localparam logic [2:0] REG_DUMP_INTERVAL = 3'd4;

   // register reset values
   localparam logic [30:0] RANGE_MIN_RST     = 31'd0;
   localparam logic [30:0] RANGE_MAX_RST     = 31'd1310720;
   localparam logic [31:0] INV_BIN_WIDTH_RST = 32'd209715;
   localparam logic [6:0]  BINS_IN_USE_RST   = 7'd64;
   localparam logic [15:0] DUMP_INTERVAL_RST = 16'd1;

   // input opcodes
   localparam logic OP_PAIR      = 1'b0;
   localparam logic OP_FRAME_END = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_WRAP,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_MAX,
      ST_SQ_MIN,
      ST_RANGE,
      ST_SQRT,
      ST_BIN_MUL,
      ST_BIN,
      ST_HIST_WR,
      ST_AREA_MUL,
      ST_AREA_ADD,
      ST_DUMP_RD,
      ST_DUMP_LD,
      ST_DUMP_OUT
   } ppdh_state_type;

   // control of the minimum image divider
   typedef struct packed {
      logic load;
      logic step;
   } ppdh_div_ctrl_type;

endpackage

// ===== hw/rtl/ppdh_req_if.sv =====
// ----------------------------------------------------------------------------
// ppdh_req_if
// pair sample / frame end input channel
// ----------------------------------------------------------------------------
interface ppdh_req_if
   import ppdh_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [COORD_WIDTH-1:0] first_x;
   logic [COORD_WIDTH-1:0] first_y;
   logic [COORD_WIDTH-1:0] second_x;
   logic [COORD_WIDTH-1:0] second_y;
   logic [30:0]            box_x;
   logic [30:0]            box_y;
   logic                   upper_leaflet;
   logic                   same_unit;

   modport source (
      output valid, opcode, first_x, first_y, second_x, second_y,
             box_x, box_y, upper_leaflet, same_unit,
      input  ready
   );
   modport sink (
      input  valid, opcode, first_x, first_y, second_x, second_y,
             box_x, box_y, upper_leaflet, same_unit,
      output ready
   );
endinterface

// ===== hw/rtl/ppdh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ppdh_rsp_if
// histogram dump output channel
// ----------------------------------------------------------------------------
interface ppdh_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  bin_index;
   logic [31:0] upper_count;
   logic [31:0] lower_count;
   logic [63:0] area_sum;
   logic [31:0] frame_number;
   logic        last;

   modport source (
      output valid, bin_index, upper_count, lower_count, area_sum, frame_number, last,
      input  ready
   );
   modport sink (
      input  valid, bin_index, upper_count, lower_count, area_sum, frame_number, last,
      output ready
   );
endinterface

// ===== hw/rtl/ppdh_csr_if.sv =====
// ----------------------------------------------------------------------------
// ppdh_csr_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface ppdh_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [31:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hw/rtl/ppdh_wrap_div.sv =====
// ----------------------------------------------------------------------------
// ppdh_wrap_div
// minimum image wrap of one axis by a bit-serial restoring divider
// ----------------------------------------------------------------------------
module ppdh_wrap_div
   import ppdh_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
   input  logic                   clock,
   input  ppdh_div_ctrl_type      ctrl,
   input  logic [COORD_WIDTH:0]   mag,
   input  logic [30:0]            box,
   output logic [30:0]            wrapped,
   output logic                   too_long
);
   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int DIV_W = ((COORD_WIDTH + 2 > 32) ? COORD_WIDTH + 2 : 32) + 1;
   localparam int RES_W = (MAG_W > 32) ? MAG_W : 32;

   logic [DIV_W-1:0] dvd_ff;
   logic [31:0]      rem_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [30:0]      box_ff;

   logic [32:0]      trial;
   logic [32:0]      two_box;
   logic [32:0]      diff;
   logic [32:0]      diff_abs;
   logic [RES_W-1:0] res;

   assign trial   = {rem_ff, dvd_ff[DIV_W-1]};
   assign two_box = {1'b0, box_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         // dividend 2|d| + box, divisor 2 box: remainder r gives |r - box| / 2
         dvd_ff <= DIV_W'({mag, 1'b0}) + DIV_W'(box);
         rem_ff <= '0;
         mag_ff <= mag;
         box_ff <= box;
      end else if (ctrl.step) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         rem_ff <= (trial >= two_box) ? 32'(trial - two_box) : trial[31:0];
      end
   end

   always_comb begin
      diff     = {1'b0, rem_ff} - {2'b00, box_ff};
      diff_abs = diff[32] ? (33'd0 - diff) : diff;
      if (box_ff == '0) begin
         res = RES_W'(mag_ff);   // zero box: axis not wrapped
      end else begin
         res = RES_W'(diff_abs[32:1]);
      end
   end

   assign wrapped  = res[30:0];
   assign too_long = |res[RES_W-1:31];

endmodule

// ===== hw/rtl/periodic_pair_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// periodic_pair_distance_histogram
// 2-d pair distance histogram under periodic boundaries with interval dumps
// ----------------------------------------------------------------------------
// One item is handled at a time. A pair sample runs through the bit-serial
// minimum image divider and the 32-step square root iteration, with five
// passes through one shared 32x32 multiplier and a read-modify-write of the
// histogram memory. Skipped pairs (same unit) are accepted in idle without
// further work. A dump sends one result per bin in use, each bin going
// through memory read, output load and transfer, then clears the histograms
// at once through per-entry valid bits; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module periodic_pair_distance_histogram
   import ppdh_pkg::*;
#(
   parameter int HIST_BINS   = HIST_BINS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   ppdh_req_if.sink   req_ch,
   ppdh_rsp_if.source rsp_ch,
   ppdh_csr_if.sink   csr_ch
);
   localparam int BIN_W = $clog2(HIST_BINS);
   localparam int DIV_W = ((COORD_WIDTH + 2 > 32) ? COORD_WIDTH + 2 : 32) + 1;
   localparam int SEQ_W = $clog2(DIV_W + 1);
   localparam int ROW_W = 2 * COUNT_WIDTH;

   // state and sequencing
   ppdh_state_type    state_ff, state_in;
   logic [SEQ_W-1:0]  cnt_ff;
   ppdh_div_ctrl_type div_ctrl;

   // configuration
   logic [30:0] rmin_ff, rmax_ff;
   logic [31:0] inv_ff;
   logic [6:0]  bins_ff;
   logic [15:0] dint_ff;

   // latched item
   logic                   upper_ff;
   logic [COORD_WIDTH-1:0] fx_ff, fy_ff, sx_ff, sy_ff;
   logic [30:0]            bx_ff, by_ff;

   // datapath
   logic [COORD_WIDTH:0] diff_x, diff_y, mag_x, mag_y;
   logic [30:0]          wrap_x, wrap_y, dx_ff, dy_ff;
   logic                 long_x, long_y;
   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_p, p_ff, acc_ff, d2_ff, hi_ff;
   logic [63:0]          v_ff, r_ff, bit_ff, r_bit;
   logic [30:0]          d_off, bin_raw;
   logic [BIN_W-1:0]     bin_sel;
   logic [6:0]           nb_m1_wide;
   logic [BIN_W-1:0]     nb_m1;
   logic                 in_range;
   logic [15:0]          fin_next, dint_eff;
   logic                 dump_now;
   logic [64:0]          area_add;

   // histogram memory, one row holds {upper, lower}
   logic [ROW_W-1:0]    hist_mem [HIST_BINS];
   logic [ROW_W-1:0]    rd_data_ff;
   logic [HIST_BINS-1:0] vld_ff;
   logic [BIN_W-1:0]    addr_ff, rd_addr;
   logic                mem_we;
   logic [ROW_W-1:0]    row_old, row_new;
   logic [COUNT_WIDTH-1:0] cnt_up, cnt_lo;

   // interval state
   logic [63:0] area_ff;
   logic [31:0] ftot_ff;
   logic [15:0] fin_ff;

   // output register
   logic [5:0]  o_bin_ff;
   logic [31:0] o_up_ff, o_lo_ff, o_frame_ff;
   logic [63:0] o_area_ff, up_wide, lo_wide;
   logic        o_last_ff;

   // ------------------------------------------------------------------
   // per-axis minimum image dividers
   // ------------------------------------------------------------------
   ppdh_wrap_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .mag      (mag_x),
      .box      (bx_ff),
      .wrapped  (wrap_x),
      .too_long (long_x)
   );

   ppdh_wrap_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .mag      (mag_y),
      .box      (by_ff),
      .wrapped  (wrap_y),
      .too_long (long_y)
   );

   // ------------------------------------------------------------------
   // combinational datapath
   // ------------------------------------------------------------------
   always_comb begin
      // signed displacement partner minus reference, then magnitude
      diff_x = {sx_ff[COORD_WIDTH-1], sx_ff} - {fx_ff[COORD_WIDTH-1], fx_ff};
      diff_y = {sy_ff[COORD_WIDTH-1], sy_ff} - {fy_ff[COORD_WIDTH-1], fy_ff};
      mag_x  = diff_x[COORD_WIDTH] ? ('0 - diff_x) : diff_x;
      mag_y  = diff_y[COORD_WIDTH] ? ('0 - diff_y) : diff_y;
   end

   // bins in use: zero acts as one, too many acts as all
   always_comb begin
      if (bins_ff == '0) begin
         nb_m1_wide = '0;
      end else if (bins_ff > 7'(HIST_BINS)) begin
         nb_m1_wide = 7'(HIST_BINS - 1);
      end else begin
         nb_m1_wide = bins_ff - 7'd1;
      end
      nb_m1 = nb_m1_wide[BIN_W-1:0];
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_SQ_X: begin
            mul_a = {1'b0, dx_ff};
            mul_b = {1'b0, dx_ff};
         end
         ST_SQ_Y: begin
            mul_a = {1'b0, dy_ff};
            mul_b = {1'b0, dy_ff};
         end
         ST_SQ_MAX: begin
            mul_a = {1'b0, rmax_ff};
            mul_b = {1'b0, rmax_ff};
         end
         ST_SQ_MIN: begin
            mul_a = {1'b0, rmin_ff};
            mul_b = {1'b0, rmin_ff};
         end
         ST_BIN_MUL: begin
            mul_a = {1'b0, d_off};
            mul_b = inv_ff;
         end
         default: begin
            mul_a = {1'b0, bx_ff};
            mul_b = {1'b0, by_ff};
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign in_range = (d2_ff < hi_ff) && (d2_ff > p_ff);
   assign r_bit    = r_ff + bit_ff;
   assign d_off    = r_ff[30:0] - rmin_ff;   // sqrt is at least range_min here
   assign bin_raw  = p_ff[62:32];
   assign bin_sel  = (bin_raw > 31'(nb_m1)) ? nb_m1 : bin_raw[BIN_W-1:0];

   assign fin_next = fin_ff + 16'd1;
   assign dint_eff = (dint_ff == '0) ? 16'd1 : dint_ff;
   assign dump_now = (fin_next >= dint_eff);
   assign area_add = {1'b0, area_ff} + 65'(p_ff[61:16]);

   // read-modify-write of one histogram row, saturating
   always_comb begin
      row_old = vld_ff[addr_ff] ? rd_data_ff : '0;
      cnt_up  = row_old[ROW_W-1:COUNT_WIDTH];
      cnt_lo  = row_old[COUNT_WIDTH-1:0];
      if (upper_ff && (cnt_up != '1)) begin
         cnt_up = cnt_up + COUNT_WIDTH'(1);
      end
      if (!upper_ff && (cnt_lo != '1)) begin
         cnt_lo = cnt_lo + COUNT_WIDTH'(1);
      end
      row_new = {cnt_up, cnt_lo};
      up_wide = 64'(row_old[ROW_W-1:COUNT_WIDTH]);
      lo_wide = 64'(row_old[COUNT_WIDTH-1:0]);
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.opcode == OP_FRAME_END) begin
                  state_in = ST_AREA_MUL;
               end else if (!req_ch.same_unit) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP:    state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == SEQ_W'(DIV_W - 1)) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP:    state_in = (long_x || long_y) ? ST_IDLE : ST_SQ_X;
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_SQ_MAX;
         ST_SQ_MAX:  state_in = ST_SQ_MIN;
         ST_SQ_MIN:  state_in = ST_RANGE;
         ST_RANGE:   state_in = in_range ? ST_SQRT : ST_IDLE;
         ST_SQRT: begin
            if (cnt_ff == SEQ_W'(31)) begin
               state_in = ST_BIN_MUL;
            end
         end
         ST_BIN_MUL:  state_in = ST_BIN;
         ST_BIN:      state_in = ST_HIST_WR;
         ST_HIST_WR:  state_in = ST_IDLE;
         ST_AREA_MUL: state_in = ST_AREA_ADD;
         ST_AREA_ADD: state_in = dump_now ? ST_DUMP_RD : ST_IDLE;
         ST_DUMP_RD:  state_in = ST_DUMP_LD;
         ST_DUMP_LD:  state_in = ST_DUMP_OUT;
         ST_DUMP_OUT: begin
            if (rsp_ch.ready) begin
               state_in = o_last_ff ? ST_IDLE : ST_DUMP_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // control outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ch.ready  = 1'b0;
      rsp_ch.valid  = 1'b0;
      div_ctrl.load = 1'b0;
      div_ctrl.step = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = addr_ff;
      unique case (state_ff)
         ST_IDLE:     req_ch.ready  = 1'b1;
         ST_PREP:     div_ctrl.load = 1'b1;
         ST_DIV:      div_ctrl.step = 1'b1;
         ST_BIN:      rd_addr       = bin_sel;
         ST_HIST_WR:  mem_we        = 1'b1;
         ST_DUMP_OUT: rsp_ch.valid  = 1'b1;
         default: begin
         end
      endcase
   end

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.bin_index    = o_bin_ff;
   assign rsp_ch.upper_count  = o_up_ff;
   assign rsp_ch.lower_count  = o_lo_ff;
   assign rsp_ch.area_sum     = o_area_ff;
   assign rsp_ch.frame_number = o_frame_ff;
   assign rsp_ch.last         = o_last_ff;

   // ------------------------------------------------------------------
   // histogram memory, registered read
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[addr_ff] <= row_new;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= '0;
         area_ff  <= '0;
         ftot_ff  <= '0;
         fin_ff   <= '0;
         rmin_ff  <= RANGE_MIN_RST;
         rmax_ff  <= RANGE_MAX_RST;
         inv_ff   <= INV_BIN_WIDTH_RST;
         bins_ff  <= BINS_IN_USE_RST;
         dint_ff  <= DUMP_INTERVAL_RST;
      end else begin
         state_ff <= state_in;

         // register file write transfer
         if (csr_ch.valid) begin
            unique case (csr_ch.reg_index)
               REG_RANGE_MIN:     rmin_ff <= csr_ch.wr_data[30:0];
               REG_RANGE_MAX:     rmax_ff <= csr_ch.wr_data[30:0];
               REG_INV_BIN_WIDTH: inv_ff  <= csr_ch.wr_data;
               REG_BINS_IN_USE:   bins_ff <= csr_ch.wr_data[6:0];
               REG_DUMP_INTERVAL: dint_ff <= csr_ch.wr_data[15:0];
               default: begin
               end
            endcase
         end

         // sequence counter for divider and square root
         if (state_ff == ST_DIV || state_ff == ST_SQRT) begin
            cnt_ff <= cnt_ff + SEQ_W'(1);
         end else begin
            cnt_ff <= '0;
         end

         if (mem_we) begin
            vld_ff[addr_ff] <= 1'b1;
         end

         // frame end bookkeeping
         if (state_ff == ST_AREA_ADD) begin
            area_ff <= area_add[64] ? '1 : area_add[63:0];
            ftot_ff <= ftot_ff + 32'd1;
            fin_ff  <= fin_next;
         end

         // last bin taken: histograms and area sum start over
         if (state_ff == ST_DUMP_OUT && rsp_ch.ready && o_last_ff) begin
            vld_ff  <= '0;
            area_ff <= '0;
            fin_ff  <= '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            fx_ff    <= req_ch.first_x;
            fy_ff    <= req_ch.first_y;
            sx_ff    <= req_ch.second_x;
            sy_ff    <= req_ch.second_y;
            bx_ff    <= req_ch.box_x;
            by_ff    <= req_ch.box_y;
            upper_ff <= req_ch.upper_leaflet;
         end
         ST_WRAP: begin
            dx_ff <= wrap_x;
            dy_ff <= wrap_y;
         end
         ST_SQ_X: p_ff <= mul_p;
         ST_SQ_Y: begin
            acc_ff <= p_ff;
            p_ff   <= mul_p;
         end
         ST_SQ_MAX: begin
            d2_ff <= acc_ff + p_ff;
            p_ff  <= mul_p;
         end
         ST_SQ_MIN: begin
            hi_ff <= p_ff;
            p_ff  <= mul_p;
         end
         ST_RANGE: begin
            v_ff   <= d2_ff;
            r_ff   <= '0;
            bit_ff <= 64'd1 << 62;
         end
         ST_SQRT: begin
            // one result bit per cycle
            if (v_ff >= r_bit) begin
               v_ff <= v_ff - r_bit;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_BIN_MUL:  p_ff    <= mul_p;
         ST_BIN:      addr_ff <= bin_sel;
         ST_AREA_MUL: begin
            p_ff    <= mul_p;
            addr_ff <= '0;
         end
         ST_DUMP_LD: begin
            o_bin_ff   <= 6'(addr_ff);
            o_up_ff    <= up_wide[31:0];
            o_lo_ff    <= lo_wide[31:0];
            o_area_ff  <= area_ff;
            o_frame_ff <= ftot_ff;
            o_last_ff  <= (addr_ff == nb_m1);
         end
         ST_DUMP_OUT: begin
            if (rsp_ch.ready && !o_last_ff) begin
               addr_ff <= addr_ff + BIN_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // no new item is taken while a dump result is pending
   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("input ready while a result is pending");

   // reported bin never passes the last bin in use
   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (addr_ff <= nb_m1))
      else $error("dump bin beyond bins in use");

   // the final transfer of a dump clears the histograms
   a_clear_after_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> (vld_ff == '0))
      else $error("histograms not cleared after dump");

   // the histogram is written only once per pair, right after its read
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ($past(state_ff) == ST_BIN))
      else $error("histogram write without read");

endmodule
